[design/gcs_pkg.sv]
// ----------------------------------------------------------------------------
// gcs_pkg
// Widths and types shared by the 2x3 genotype chi-square pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcs_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int FRACTION_BITS = 16;
  localparam int CHI_BITS      = 39;
  localparam int LANES         = 6;

  localparam int ROW_BITS  = COUNT_BITS + 2;
  localparam int COL_BITS  = COUNT_BITS + 1;
  localparam int TOT_BITS  = COUNT_BITS + 3;
  localparam int PROD_BITS = TOT_BITS + COUNT_BITS;
  localparam int DIFF_BITS = PROD_BITS;
  localparam int LO_BITS   = (DIFF_BITS + 1) / 2;
  localparam int HI_BITS   = DIFF_BITS - LO_BITS;
  localparam int SQ_BITS   = 2 * DIFF_BITS;
  localparam int NUM_BITS  = SQ_BITS + FRACTION_BITS;
  localparam int NR_BITS   = TOT_BITS + ROW_BITS;
  localparam int DEN_BITS  = NR_BITS + COL_BITS;
  localparam int PAIR_BITS = CHI_BITS + 1;
  localparam int SUM_BITS  = CHI_BITS + 2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [TOT_BITS-1:0]   tot_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [NR_BITS-1:0]    nr_t;
  typedef logic [NUM_BITS-1:0]   num_t;
  typedef logic [DEN_BITS-1:0]   den_t;
  typedef logic [CHI_BITS-1:0]   chi_t;

endpackage

`default_nettype wire

[design/genotype_chi_square_2x3.sv]
// ----------------------------------------------------------------------------
// genotype_chi_square_2x3
// Pearson chi-square of a 2x3 case/control genotype table in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one item of six genotype counts per cycle while it has
// room, and returns the exact chi-square, each cell term truncated, with
// 16 fraction bits. The pipeline has five stages of totals, products and
// squaring, 40 stages of the divider (an entry stage, then one quotient bit
// per stage, six lanes in parallel) and two stages of summation. Bubbles
// close up under back-pressure, so a stalled output still lets items enter
// while the pipeline has room.
`default_nettype none

module genotype_chi_square_2x3 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] case_hom_one_i,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] case_het_i,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] case_hom_two_i,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] ctrl_hom_one_i,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] ctrl_het_i,
  input  wire logic [gcs_pkg::COUNT_BITS-1:0] ctrl_hom_two_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gcs_pkg::CHI_BITS-1:0]       chi_value_o,
  output logic                               empty_table_o
);

  localparam int L = gcs_pkg::LANES;

  logic v_a_q, v_b_q, v_c_q, v_d_q, v_e_q, v_f_q, v_g_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g;
  logic div_in_ready, div_out_valid, div_empty;

  // Stage A: counts and margins.
  gcs_pkg::count_t cnt_a_q [L];
  gcs_pkg::row_t   row_a_q [2];
  gcs_pkg::col_t   col_a_q [3];
  gcs_pkg::tot_t   tot_a_q;
  gcs_pkg::count_t cnt_in  [L];
  gcs_pkg::row_t   row_d   [2];
  gcs_pkg::col_t   col_d   [3];

  // Stage B: products.
  gcs_pkg::prod_t  no_b_q [L];
  gcs_pkg::prod_t  rc_b_q [L];
  gcs_pkg::nr_t    nr_b_q [2];
  gcs_pkg::col_t   col_b_q [3];
  logic [L-1:0]    skip_b_q;
  logic            empty_b_q;

  // Stage C: difference and denominator.
  gcs_pkg::prod_t  diff_c_q [L];
  gcs_pkg::den_t   den_c_q  [L];
  logic [L-1:0]    skip_c_q;
  logic            empty_c_q;

  // Stage D: partial squares.
  logic [2*gcs_pkg::HI_BITS-1:0]                  hh_d_q [L];
  logic [gcs_pkg::HI_BITS+gcs_pkg::LO_BITS-1:0]   hl_d_q [L];
  logic [2*gcs_pkg::LO_BITS-1:0]                  ll_d_q [L];
  gcs_pkg::den_t   den_d_q [L];
  logic [L-1:0]    skip_d_q;
  logic            empty_d_q;

  // Stage E: scaled numerator.
  gcs_pkg::num_t   num_e_q [L];
  gcs_pkg::num_t   num_e_d [L];
  gcs_pkg::den_t   den_e_q [L];
  logic [L-1:0]    skip_e_q;
  logic            empty_e_q;

  gcs_pkg::chi_t   term [L];

  logic [gcs_pkg::PAIR_BITS-1:0] pair_f_q [3];
  logic            empty_f_q;
  logic [gcs_pkg::SUM_BITS-1:0]  sum_g;
  gcs_pkg::chi_t   chi_g_q;
  logic            empty_g_q;

  assign rdy_g = !v_g_q || out_ready_i;
  assign rdy_f = !v_f_q || rdy_g;
  assign rdy_e = !v_e_q || div_in_ready;
  assign rdy_d = !v_d_q || rdy_e;
  assign rdy_c = !v_c_q || rdy_d;
  assign rdy_b = !v_b_q || rdy_c;
  assign rdy_a = !v_a_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_comb begin
    cnt_in[0] = case_hom_one_i;
    cnt_in[1] = case_het_i;
    cnt_in[2] = case_hom_two_i;
    cnt_in[3] = ctrl_hom_one_i;
    cnt_in[4] = ctrl_het_i;
    cnt_in[5] = ctrl_hom_two_i;
    row_d[0] = gcs_pkg::ROW_BITS'(cnt_in[0]) + gcs_pkg::ROW_BITS'(cnt_in[1])
             + gcs_pkg::ROW_BITS'(cnt_in[2]);
    row_d[1] = gcs_pkg::ROW_BITS'(cnt_in[3]) + gcs_pkg::ROW_BITS'(cnt_in[4])
             + gcs_pkg::ROW_BITS'(cnt_in[5]);
    for (int c = 0; c < 3; c++) begin
      col_d[c] = gcs_pkg::COL_BITS'(cnt_in[c]) + gcs_pkg::COL_BITS'(cnt_in[3+c]);
    end
  end

  // The square of the difference is built from three narrower products.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      logic [gcs_pkg::SQ_BITS-1:0] sq;
      sq = (gcs_pkg::SQ_BITS'(hh_d_q[l]) << (2 * gcs_pkg::LO_BITS))
         + (gcs_pkg::SQ_BITS'(hl_d_q[l]) << (gcs_pkg::LO_BITS + 1))
         + gcs_pkg::SQ_BITS'(ll_d_q[l]);
      num_e_d[l] = {sq, {gcs_pkg::FRACTION_BITS{1'b0}}};
    end
  end

  always_comb begin
    sum_g = gcs_pkg::SUM_BITS'(pair_f_q[0]) + gcs_pkg::SUM_BITS'(pair_f_q[1])
          + gcs_pkg::SUM_BITS'(pair_f_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= in_valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_e) v_e_q <= v_d_q;
      if (rdy_f) v_f_q <= div_out_valid;
      if (rdy_g) v_g_q <= v_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      cnt_a_q <= cnt_in;
      row_a_q <= row_d;
      col_a_q <= col_d;
      tot_a_q <= gcs_pkg::TOT_BITS'(row_d[0]) + gcs_pkg::TOT_BITS'(row_d[1]);
    end
    if (rdy_b && v_a_q) begin
      for (int l = 0; l < L; l++) begin
        no_b_q[l]   <= gcs_pkg::PROD_BITS'(tot_a_q) * gcs_pkg::PROD_BITS'(cnt_a_q[l]);
        rc_b_q[l]   <= gcs_pkg::PROD_BITS'(row_a_q[l/3])
                     * gcs_pkg::PROD_BITS'(col_a_q[l%3]);
        skip_b_q[l] <= (row_a_q[l/3] == '0) || (col_a_q[l%3] == '0);
      end
      for (int r = 0; r < 2; r++) begin
        nr_b_q[r] <= gcs_pkg::NR_BITS'(tot_a_q) * gcs_pkg::NR_BITS'(row_a_q[r]);
      end
      col_b_q   <= col_a_q;
      empty_b_q <= tot_a_q == '0;
    end
    if (rdy_c && v_b_q) begin
      for (int l = 0; l < L; l++) begin
        diff_c_q[l] <= (no_b_q[l] >= rc_b_q[l]) ? no_b_q[l] - rc_b_q[l]
                                                : rc_b_q[l] - no_b_q[l];
        den_c_q[l]  <= gcs_pkg::DEN_BITS'(nr_b_q[l/3])
                     * gcs_pkg::DEN_BITS'(col_b_q[l%3]);
      end
      skip_c_q  <= skip_b_q;
      empty_c_q <= empty_b_q;
    end
    if (rdy_d && v_c_q) begin
      for (int l = 0; l < L; l++) begin
        hh_d_q[l] <= diff_c_q[l][gcs_pkg::DIFF_BITS-1:gcs_pkg::LO_BITS]
                   * diff_c_q[l][gcs_pkg::DIFF_BITS-1:gcs_pkg::LO_BITS];
        hl_d_q[l] <= diff_c_q[l][gcs_pkg::DIFF_BITS-1:gcs_pkg::LO_BITS]
                   * diff_c_q[l][gcs_pkg::LO_BITS-1:0];
        ll_d_q[l] <= diff_c_q[l][gcs_pkg::LO_BITS-1:0]
                   * diff_c_q[l][gcs_pkg::LO_BITS-1:0];
      end
      den_d_q   <= den_c_q;
      skip_d_q  <= skip_c_q;
      empty_d_q <= empty_c_q;
    end
    if (rdy_e && v_d_q) begin
      num_e_q   <= num_e_d;
      den_e_q   <= den_d_q;
      skip_e_q  <= skip_d_q;
      empty_e_q <= empty_d_q;
    end
    if (rdy_f && div_out_valid) begin
      for (int p = 0; p < 3; p++) begin
        pair_f_q[p] <= gcs_pkg::PAIR_BITS'(term[2*p]) + gcs_pkg::PAIR_BITS'(term[2*p+1]);
      end
      empty_f_q <= div_empty;
    end
    if (rdy_g && v_f_q) begin
      // Saturate should the total ever exceed the output range.
      chi_g_q   <= (sum_g > gcs_pkg::SUM_BITS'({gcs_pkg::CHI_BITS{1'b1}}))
                   ? '1 : sum_g[gcs_pkg::CHI_BITS-1:0];
      empty_g_q <= empty_f_q;
    end
  end

  gcs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_e_q),
    .in_ready_o  (div_in_ready),
    .num_i       (num_e_q),
    .den_i       (den_e_q),
    .skip_i      (skip_e_q),
    .empty_i     (empty_e_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_f),
    .term_o      (term),
    .empty_o     (div_empty)
  );

  assign out_valid_o   = v_g_q;
  assign chi_value_o   = chi_g_q;
  assign empty_table_o = empty_g_q;

endmodule

`default_nettype wire

[design/gcs_divider.sv]
// ----------------------------------------------------------------------------
// gcs_divider
// Six-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_divider (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  gcs_pkg::num_t       num_i [gcs_pkg::LANES],
  input  gcs_pkg::den_t       den_i [gcs_pkg::LANES],
  input  wire logic [gcs_pkg::LANES-1:0] skip_i,
  input  wire logic           empty_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gcs_pkg::chi_t       term_o [gcs_pkg::LANES],
  output logic                empty_o
);

  localparam int Steps   = gcs_pkg::CHI_BITS;
  localparam int TopBits = gcs_pkg::NUM_BITS - gcs_pkg::CHI_BITS;
  localparam int CmpBits = (TopBits > gcs_pkg::DEN_BITS) ? TopBits : gcs_pkg::DEN_BITS;
  localparam int L       = gcs_pkg::LANES;

  logic [Steps:0]   v_q;
  logic [Steps+1:0] rdy;

  gcs_pkg::den_t rem_q  [Steps+1][L];
  gcs_pkg::den_t rem_d  [Steps+1][L];
  gcs_pkg::chi_t low_q  [Steps+1][L];
  gcs_pkg::chi_t low_d  [Steps+1][L];
  gcs_pkg::chi_t quot_q [Steps+1][L];
  gcs_pkg::chi_t quot_d [Steps+1][L];
  gcs_pkg::den_t den_q  [Steps+1][L];
  logic [L-1:0]  ovf_q  [Steps+1];
  logic [L-1:0]  ovf_d  [Steps+1];
  logic [L-1:0]  skip_q [Steps+1];
  logic [Steps:0] empty_q;

  always_comb begin
    rdy[Steps+1] = out_ready_i;
    for (int s = Steps; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end
  assign in_ready_o = rdy[0];

  // Entry: the upper numerator bits must stay below the divisor, or the
  // quotient does not fit and the term saturates.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      logic [TopBits-1:0] top;
      top = num_i[l][gcs_pkg::NUM_BITS-1:gcs_pkg::CHI_BITS];
      ovf_d[0][l]  = CmpBits'(top) >= CmpBits'(den_i[l]);
      rem_d[0][l]  = ovf_d[0][l] ? '0 : gcs_pkg::DEN_BITS'(top);
      low_d[0][l]  = num_i[l][gcs_pkg::CHI_BITS-1:0];
      quot_d[0][l] = '0;
    end
    for (int s = 1; s <= Steps; s++) begin
      ovf_d[s] = ovf_q[s-1];
      for (int l = 0; l < L; l++) begin
        logic [gcs_pkg::DEN_BITS:0] trial;
        logic [gcs_pkg::DEN_BITS:0] dext;
        logic                       ge;
        trial = {rem_q[s-1][l], low_q[s-1][l][gcs_pkg::CHI_BITS-1]};
        dext  = {1'b0, den_q[s-1][l]};
        ge    = trial >= dext;
        rem_d[s][l]  = ge ? gcs_pkg::DEN_BITS'(trial - dext)
                          : gcs_pkg::DEN_BITS'(trial);
        low_d[s][l]  = {low_q[s-1][l][gcs_pkg::CHI_BITS-2:0], 1'b0};
        quot_d[s][l] = {quot_q[s-1][l][gcs_pkg::CHI_BITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= Steps; s++) begin
        if (rdy[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0]   <= rem_d[0];
      low_q[0]   <= low_d[0];
      quot_q[0]  <= quot_d[0];
      den_q[0]   <= den_i;
      ovf_q[0]   <= ovf_d[0];
      skip_q[0]  <= skip_i;
      empty_q[0] <= empty_i;
    end
    for (int s = 1; s <= Steps; s++) begin
      if (rdy[s] && v_q[s-1]) begin
        rem_q[s]   <= rem_d[s];
        low_q[s]   <= low_d[s];
        quot_q[s]  <= quot_d[s];
        den_q[s]   <= den_q[s-1];
        ovf_q[s]   <= ovf_d[s];
        skip_q[s]  <= skip_q[s-1];
        empty_q[s] <= empty_q[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (skip_q[Steps][l]) begin
        term_o[l] = '0;
      end else if (ovf_q[Steps][l]) begin
        term_o[l] = '1;
      end else begin
        term_o[l] = quot_q[Steps][l];
      end
    end
  end

  assign out_valid_o = v_q[Steps];
  assign empty_o     = empty_q[Steps];

endmodule

`default_nettype wire

[dv/genotype_chi_square_2x3_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// genotype_chi_square_2x3_tb
// Self-checking bench for the 2x3 genotype chi-square pipeline.
// ----------------------------------------------------------------------------
// Count sets are sent through the input handshake and the exact statistic is
// predicted in wide integer arithmetic at the moment each item is accepted.
// Every returned item is checked against the oldest prediction. Directed
// tables come first, then random tables under three idling patterns.
`default_nettype none

module genotype_chi_square_2x3_tb;

  typedef struct packed {
    gcs_pkg::chi_t chi;
    logic          empty;
  } chi_result_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  gcs_pkg::count_t case_hom_one_i = '0, case_het_i = '0, case_hom_two_i = '0;
  gcs_pkg::count_t ctrl_hom_one_i = '0, ctrl_het_i = '0, ctrl_hom_two_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  gcs_pkg::chi_t chi_value_o;
  logic   empty_table_o;

  chi_result_t pending_chi[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;

  genotype_chi_square_2x3 u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .case_hom_one_i, .case_het_i, .case_hom_two_i,
    .ctrl_hom_one_i, .ctrl_het_i, .ctrl_hom_two_i,
    .out_valid_o, .out_ready_i, .chi_value_o, .empty_table_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Exact Pearson statistic; each cell term is truncated before summing.
  function automatic chi_result_t predict_chi(input gcs_pkg::count_t cnt [6]);
    logic [127:0] rows [2];
    logic [127:0] cols [3];
    logic [127:0] total, no, rc, diff, den, term, sum;
    chi_result_t res;
    rows[0] = cnt[0] + cnt[1] + cnt[2];
    rows[1] = cnt[3] + cnt[4] + cnt[5];
    for (int i = 0; i < 3; i++) cols[i] = cnt[i] + cnt[3+i];
    total = rows[0] + rows[1];
    sum = '0;
    res.empty = (total == 0);
    for (int i = 0; i < 6; i++) begin
      if (rows[i/3] != 0 && cols[i%3] != 0 && total != 0) begin
        no = total * cnt[i];
        rc = rows[i/3] * cols[i%3];
        diff = (no >= rc) ? no - rc : rc - no;
        den = total * rows[i/3] * cols[i%3];
        term = ((diff * diff) << gcs_pkg::FRACTION_BITS) / den;
        sum = sum + term;
      end
    end
    res.chi = (sum > {gcs_pkg::CHI_BITS{1'b1}}) ? {gcs_pkg::CHI_BITS{1'b1}}
                                                : sum[gcs_pkg::CHI_BITS-1:0];
    return res;
  endfunction

  // Sends one count set, idling beforehand at the current sender rate.
  // Called at a rising edge, and returns at the edge that accepts the item.
  task automatic send_counts(input gcs_pkg::count_t cnt [6]);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat (1 + $urandom_range(2)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    case_hom_one_i <= cnt[0];
    case_het_i     <= cnt[1];
    case_hom_two_i <= cnt[2];
    ctrl_hom_one_i <= cnt[3];
    ctrl_het_i     <= cnt[4];
    ctrl_hom_two_i <= cnt[5];
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    pending_chi = {pending_chi, predict_chi(cnt)};
  endtask

  task automatic send_table(input int unsigned a, b, c, d, e, f);
    gcs_pkg::count_t cnt [6];
    cnt = '{gcs_pkg::count_t'(a), gcs_pkg::count_t'(b), gcs_pkg::count_t'(c),
            gcs_pkg::count_t'(d), gcs_pkg::count_t'(e), gcs_pkg::count_t'(f)};
    send_counts(cnt);
  endtask

  task automatic test_directed();
    int unsigned mx;
    mx = (1 << gcs_pkg::COUNT_BITS) - 1;
    send_table(0, 0, 0, 0, 0, 0);                 // empty table
    send_table(mx, mx, mx, mx, mx, mx);
    send_table(mx, 0, 0, 0, 0, mx);
    send_table(0, 0, mx, mx, 0, 0);
    send_table(1, 0, 0, 0, 0, 0);                 // single sample
    send_table(0, 0, 0, 0, 0, 1);
    send_table(5, 7, 9, 0, 0, 0);                 // no controls
    send_table(0, 0, 0, 3, 4, 5);                 // no cases
    send_table(10, 0, 20, 30, 0, 40);             // empty heterozygote column
    send_table(0, 12, 0, 0, 8, 0);                // only one column populated
    send_table(100, 200, 300, 100, 200, 300);     // perfectly balanced
    send_table(mx, 1, 0, 0, 1, mx);
    send_table(1, mx, 1, mx, 1, mx);
    send_table(mx, mx, mx, 0, 0, 1);
    send_table(37, 0, 0, 0, 0, 41);
    send_table(mx, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int unsigned n_items);
    gcs_pkg::count_t cnt [6];
    int unsigned shape;
    for (int k = 0; k < n_items; k++) begin
      shape = $urandom_range(9);
      for (int i = 0; i < 6; i++) begin
        if (shape < 4) cnt[i] = gcs_pkg::count_t'($urandom);
        else if (shape < 8) cnt[i] = gcs_pkg::count_t'($urandom_range(2000));
        else cnt[i] = ($urandom_range(2) == 0) ? '0 : gcs_pkg::count_t'($urandom);
      end
      // Now and then zero a whole column or row to reach the skipped cells.
      if ($urandom_range(9) == 0) begin
        shape = $urandom_range(2);
        cnt[shape] = '0;
        cnt[shape+3] = '0;
      end else if ($urandom_range(19) == 0) begin
        shape = 3 * $urandom_range(1);
        cnt[shape] = '0; cnt[shape+1] = '0; cnt[shape+2] = '0;
      end
      send_counts(cnt);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Outputs change only after rising edges, so the falling edge sees the
  // values that the next rising edge will accept.
  always @(negedge clk_i) begin
    chi_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chi.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: chi=%0d empty=%0b", chi_value_o, empty_table_o);
      end else begin
        exp_res = pending_chi.pop_front();
        if (chi_value_o !== exp_res.chi || empty_table_o !== exp_res.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: chi exp=%0d got=%0d, empty exp=%0b got=%0b",
                     exp_res.chi, chi_value_o, exp_res.empty, empty_table_o);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    send_idle_pct = 37;
    recv_idle_pct = 83;
    test_random(400);
    send_idle_pct = 83;
    recv_idle_pct = 37;
    test_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    in_valid_i <= 1'b0;
    while (pending_chi.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (pending_chi.size() == 0 && mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/gcs_pkg.sv
design/gcs_divider.sv
design/genotype_chi_square_2x3.sv
dv/genotype_chi_square_2x3_tb.sv
